// ===== design/mtwg_pkg.sv =====
// package: constants and word functions of the mt19937 word generator
package mtwg_pkg;

	localparam int unsigned ADDR_W = 10;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [31:0] word_t;

	localparam addr_t WORDS_LAST = addr_t'(623);
	localparam addr_t FAR_SHIFT  = addr_t'(397);
	localparam addr_t FAR_BACK   = addr_t'(227);

	localparam word_t MATRIX_A    = 32'h9908_b0df;
	localparam word_t UPPER_MASK  = 32'h8000_0000;
	localparam word_t LOWER_MASK  = 32'h7fff_ffff;
	localparam word_t INIT_MULT   = 32'd1812433253;
	localparam word_t TEMPER_B    = 32'h9d2c_5680;
	localparam word_t TEMPER_C    = 32'hefc6_0000;
	localparam word_t SEED_RESET  = 32'd5489;

	function automatic word_t mix_step(word_t far_word, word_t here, word_t nxt);
		word_t y;
		word_t mag;
		y   = (here & UPPER_MASK) | (nxt & LOWER_MASK);
		mag = nxt[0] ? MATRIX_A : 32'h0000_0000;
		return far_word ^ (y >> 1) ^ mag;
	endfunction

	function automatic word_t temper(word_t w);
		word_t y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic addr_t wrap_inc(addr_t a);
		return (a == WORDS_LAST) ? addr_t'(0) : addr_t'(a + addr_t'(1));
	endfunction

	function automatic addr_t far_addr(addr_t a);
		return (a < FAR_BACK) ? addr_t'(a + FAR_SHIFT) : addr_t'(a - FAR_BACK);
	endfunction

endpackage

// ===== design/mt19937_word_generator_unit.sv =====
// top level: mt19937 word generator with on-the-fly twisting
//
// usage:
//   an item is taken at a rising edge with start high and busy low.
//   command 0 draws one tempered word, command 1 reseeds from seed_value.
//   a draw gives one result: random_word with random_word_valid high for
//   exactly one cycle, registered in the write state that follows its read state.
//   a reseed gives no result and keeps busy high while the seed recurrence
//   fills the state memory, each word by a registered multiply, then an add.
//   back-to-back draws overlap, the next taken in the last one's write state;
//   the single memory read port (next and far word per draw) sets the pace.
//   the first draw after reset seeds from default_seed first: the fill runs,
//   then an extra read state, then that draw's own read and write states.
//   default_seed is written at an edge with default_seed_we high; the user
//   does so idle only, unchecked. reset clears position and seeded flag and sets
//   default_seed to 5489; the state memory is not cleared.
//   the receiver cannot stall: results are never held back.
module mt19937_word_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] seed_value,
	input  logic        default_seed_we,
	input  logic [31:0] default_seed,
	output logic [31:0] random_word,
	output logic        random_word_valid
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SMUL = 3'd1;
	localparam logic [2:0] ST_SADD = 3'd2;
	localparam logic [2:0] ST_RD1  = 3'd3;
	localparam logic [2:0] ST_RD2  = 3'd4;
	localparam logic [2:0] ST_WR   = 3'd5;

	logic [2:0]      state_q;
	mtwg_pkg::addr_t pos_q;
	mtwg_pkg::addr_t idx_q;
	logic            seeded_q;
	logic            pending_q;
	logic            valid_q;
	mtwg_pkg::word_t dseed_q;

	mtwg_pkg::word_t prev_q;
	mtwg_pkg::word_t prod_q;
	mtwg_pkg::word_t here_q;
	mtwg_pkg::word_t nxt_q;
	mtwg_pkg::word_t word_q;

	logic            accept;
	mtwg_pkg::addr_t pos_inc;
	mtwg_pkg::addr_t pos_cur;
	mtwg_pkg::addr_t idx_inc;
	mtwg_pkg::word_t new_word;
	mtwg_pkg::word_t seed_mix;

	logic            ram_we;
	mtwg_pkg::addr_t ram_waddr;
	mtwg_pkg::word_t ram_wdata;
	mtwg_pkg::addr_t ram_raddr;
	mtwg_pkg::word_t ram_rdata;

	assign busy     = (state_q != ST_IDLE) && (state_q != ST_WR);
	assign accept   = start && !busy;
	assign pos_inc  = mtwg_pkg::wrap_inc(pos_q);
	assign pos_cur  = (state_q == ST_WR) ? pos_inc : pos_q;
	assign idx_inc  = mtwg_pkg::addr_t'(idx_q + mtwg_pkg::addr_t'(1));
	assign new_word = mtwg_pkg::mix_step(ram_rdata, here_q, nxt_q);
	assign seed_mix = prev_q ^ (prev_q >> 30);

	assign ram_we    = (state_q == ST_SMUL) || (state_q == ST_WR);
	assign ram_waddr = (state_q == ST_SMUL) ? idx_q : pos_q;
	assign ram_wdata = (state_q == ST_SMUL) ? prev_q : new_word;
	assign ram_raddr = (state_q == ST_RD2) ? mtwg_pkg::far_addr(pos_q)
	                                       : mtwg_pkg::wrap_inc(pos_cur);

	mtwg_state_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			idx_q     <= '0;
			seeded_q  <= 1'b0;
			pending_q <= 1'b0;
			valid_q   <= 1'b0;
			dseed_q   <= mtwg_pkg::SEED_RESET;
		end else begin
			valid_q <= 1'b0;
			if (default_seed_we) begin
				dseed_q <= default_seed;
			end
			case (state_q)
				ST_SMUL: begin
					if (idx_q == mtwg_pkg::WORDS_LAST) begin
						seeded_q <= 1'b1;
						pos_q    <= '0;
						state_q  <= pending_q ? ST_RD1 : ST_IDLE;
					end else begin
						state_q <= ST_SADD;
					end
				end
				ST_SADD: begin
					idx_q   <= idx_inc;
					state_q <= ST_SMUL;
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					pos_q   <= pos_inc;
					valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (accept) begin
				if (command || !seeded_q) begin
					idx_q     <= '0;
					pending_q <= !command;
					state_q   <= ST_SMUL;
				end else begin
					state_q <= ST_RD2;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_SMUL) begin
			prod_q <= 32'(mtwg_pkg::INIT_MULT * seed_mix);
		end
		if (state_q == ST_SADD) begin
			prev_q <= prod_q + {22'd0, idx_inc};
		end
		if (state_q == ST_RD2) begin
			nxt_q <= ram_rdata;
		end
		if (state_q == ST_WR) begin
			here_q <= nxt_q;
			word_q <= mtwg_pkg::temper(new_word);
		end
		if (accept && (command || !seeded_q)) begin
			prev_q <= command ? seed_value : dseed_q;
			here_q <= command ? seed_value : dseed_q;
		end
	end

	assign random_word       = word_q;
	assign random_word_valid = valid_q;

endmodule

// ===== design/mtwg_state_ram.sv =====
// state memory: 624 x 32, one write port, one registered read port
module mtwg_state_ram (
	input  logic             clk,
	input  logic             we,
	input  mtwg_pkg::addr_t  waddr,
	input  mtwg_pkg::word_t  wdata,
	input  mtwg_pkg::addr_t  raddr,
	output mtwg_pkg::word_t  rdata
);

	mtwg_pkg::word_t mem [0:623];
	mtwg_pkg::word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/mtwg_checker.sv =====
// checker: port-level properties of the mt19937 word generator
module mtwg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        command,
	input logic        random_word_valid
);

	// a reseed item takes the block busy for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command) |=> busy)
		else $error("reseed item not followed by busy");

	// a draw item takes the block busy for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !command) |=> busy)
		else $error("draw item not followed by busy");

	// results never come on consecutive cycles
	assert property (@(posedge clk) disable iff (!arst_n)
		random_word_valid |=> !random_word_valid)
		else $error("results on consecutive cycles");

	// each result is preceded by a busy read state, the one before the write state
	assert property (@(posedge clk) disable iff (!arst_n)
		random_word_valid |-> $past(busy, 2))
		else $error("result without a preceding draw");

endmodule

bind mt19937_word_generator_unit mtwg_checker u_mtwg_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.start             (start),
	.busy              (busy),
	.command           (command),
	.random_word_valid (random_word_valid)
);

// ===== sim/tb_mt19937_word_generator_unit.sv =====
`timescale 1ns / 100ps
// testbench for the mt19937 word generator: seeded draws checked against a software twister
module tb_mt19937_word_generator_unit;

	typedef enum logic {
		CMD_DRAW   = 1'b0,
		CMD_RESEED = 1'b1
	} cmd_e;

	localparam int unsigned MT_N          = 624;
	localparam int unsigned MT_M          = 397;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT   = 600000;

	class mt_word_board;
		mtwg_pkg::word_t mt_words[MT_N];
		int unsigned     next_pos;
		bit              seeded;
		mtwg_pkg::word_t dflt_seed;
		mtwg_pkg::word_t pending_words[$];
		int unsigned     errors;
		int unsigned     draws;
		int unsigned     reseeds;
		int unsigned     checked;
		int unsigned     wraps;

		function new();
			next_pos  = 0;
			seeded    = 1'b0;
			dflt_seed = mtwg_pkg::SEED_RESET;
		endfunction

		function void fill_from_seed(mtwg_pkg::word_t s);
			mtwg_pkg::word_t p;
			mt_words[0] = s;
			for (int i = 1; i < MT_N; i++) begin
				p = mt_words[i-1];
				mt_words[i] = mtwg_pkg::word_t'(mtwg_pkg::INIT_MULT * (p ^ (p >> 30))
					+ mtwg_pkg::word_t'(i));
			end
			next_pos = 0;
			seeded   = 1'b1;
		endfunction

		function void take_item(cmd_e cmd, mtwg_pkg::word_t seed);
			mtwg_pkg::word_t y;
			int unsigned nx;
			int unsigned fr;
			if (cmd == CMD_RESEED) begin
				reseeds++;
				fill_from_seed(seed);
				return;
			end
			draws++;
			if (next_pos == 0) begin
				if (!seeded)
					fill_from_seed(dflt_seed);
				for (int k = 0; k < MT_N; k++) begin
					nx = (k == MT_N - 1) ? 0 : k + 1;
					fr = (k + MT_M) % MT_N;
					y  = (mt_words[k] & mtwg_pkg::UPPER_MASK)
						| (mt_words[nx] & mtwg_pkg::LOWER_MASK);
					mt_words[k] = mt_words[fr] ^ (y >> 1)
						^ (mt_words[nx][0] ? mtwg_pkg::MATRIX_A : '0);
				end
			end
			y = mt_words[next_pos];
			y = y ^ (y >> 11);
			y = y ^ ((y << 7) & mtwg_pkg::TEMPER_B);
			y = y ^ ((y << 15) & mtwg_pkg::TEMPER_C);
			y = y ^ (y >> 18);
			pending_words.push_back(y);
			next_pos++;
			if (next_pos == MT_N) begin
				next_pos = 0;
				wraps++;
			end
		endfunction

		function void check_word(mtwg_pkg::word_t got);
			mtwg_pkg::word_t want;
			if (pending_words.size() == 0) begin
				errors++;
				$error("random_word: expected none, got %h", got);
				return;
			end
			want = pending_words.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				$error("random_word: expected %h, got %h", want, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [31:0] seed_value;
	logic        default_seed_we;
	logic [31:0] default_seed;
	logic [31:0] random_word;
	logic        random_word_valid;

	mt_word_board scb = new();
	int unsigned  idle_pct;
	int unsigned  cycles;

	mt19937_word_generator_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.command           (command),
		.seed_value        (seed_value),
		.default_seed_we   (default_seed_we),
		.default_seed      (default_seed),
		.random_word       (random_word),
		.random_word_valid (random_word_valid)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && random_word_valid)
			scb.check_word(random_word);
	end

	function automatic mtwg_pkg::word_t pick_seed();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return mtwg_pkg::word_t'($urandom_range(15));
			default: return mtwg_pkg::word_t'($urandom);
		endcase
	endfunction

	task automatic send_item(cmd_e cmd, mtwg_pkg::word_t seed);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		command    <= cmd;
		seed_value <= seed;
		do @(posedge clk); while (busy);
		scb.take_item(cmd, seed);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (busy || scb.pending_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_default_seed(mtwg_pkg::word_t v);
		@(negedge clk);
		default_seed_we <= 1'b1;
		default_seed    <= v;
		@(negedge clk);
		default_seed_we <= 1'b0;
		scb.dflt_seed = v;
	endtask

	task automatic run_random(int unsigned n, int unsigned reseed_odds);
		for (int unsigned i = 0; i < n; i++) begin
			if (reseed_odds != 0 && $urandom_range(reseed_odds - 1) == 0)
				send_item(CMD_RESEED, pick_seed());
			else
				send_item(CMD_DRAW, mtwg_pkg::word_t'($urandom));
			if ($urandom_range(99) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		command         = CMD_DRAW;
		seed_value      = '0;
		default_seed_we = 1'b0;
		default_seed    = '0;
		idle_pct        = 0;
		cycles          = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// draw before any seed uses the default seed register
		write_default_seed(32'hffff_ffff);
		send_item(CMD_DRAW, 32'hffff_ffff);
		send_item(CMD_DRAW, 32'h0000_0000);
		send_item(CMD_DRAW, 32'ha5a5_a5a5);
		send_item(CMD_RESEED, 32'h0000_0000);
		send_item(CMD_DRAW, 32'h5a5a_5a5a);
		send_item(CMD_DRAW, 32'hffff_ffff);
		send_item(CMD_RESEED, 32'hffff_ffff);
		send_item(CMD_DRAW, 32'h0000_0000);
		send_item(CMD_RESEED, 32'h8000_0000);
		send_item(CMD_DRAW, 32'h0000_0000);
		send_item(CMD_RESEED, 32'h0000_0001);
		send_item(CMD_DRAW, 32'h0000_0000);
		send_item(CMD_RESEED, mtwg_pkg::SEED_RESET);
		send_item(CMD_DRAW, 32'h0000_0000);
		send_item(CMD_DRAW, 32'h0000_0000);
		send_item(CMD_DRAW, 32'h0000_0000);
		// back-to-back reseeds, only the last counts
		send_item(CMD_RESEED, 32'h7fff_ffff);
		send_item(CMD_RESEED, 32'h1234_5678);
		send_item(CMD_DRAW, 32'hffff_ffff);
		wait_drained();
		write_default_seed(32'h0000_0000);

		idle_pct = 6;
		run_random(150, 40);
		wait_drained();
		write_default_seed(mtwg_pkg::word_t'($urandom));

		idle_pct = 68;
		run_random(100, 40);
		wait_drained();
		write_default_seed(mtwg_pkg::SEED_RESET);

		// long reseed-free run so the read position wraps
		idle_pct = 0;
		send_item(CMD_RESEED, mtwg_pkg::word_t'($urandom));
		run_random(650, 0);
		wait_drained();

		if (scb.pending_words.size() != 0) begin
			scb.errors++;
			$error("random_word: %0d expected words never arrived", scb.pending_words.size());
		end
		$display("run: %0d draws, %0d reseeds, %0d words checked", scb.draws, scb.reseeds,
			scb.checked);
		$display("run: %0d position wraps, %0d cycles", scb.wraps, cycles);
		if (scb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mtwg_pkg.sv
design/mtwg_state_ram.sv
design/mt19937_word_generator_unit.sv
design/mtwg_checker.sv
sim/tb_mt19937_word_generator_unit.sv
